@@ hdl/act_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// act_pkg: shared types and constants
// Types, codes and sizes used by the front, the queue and the back end.
// ----------------------------------------------------------------------------
package act_pkg;
    localparam int ENTRIES   = 16;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);

    localparam logic [1:0] MODE_REQ   = 2'd0;
    localparam logic [1:0] MODE_REPLY = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    localparam logic [1:0] ST_FREE     = 2'd0;
    localparam logic [1:0] ST_PENDING  = 2'd1;
    localparam logic [1:0] ST_RESOLVED = 2'd2;

    localparam logic [2:0] RS_PRESENT  = 3'd0;
    localparam logic [2:0] RS_NEW      = 3'd1;
    localparam logic [2:0] RS_FULL     = 3'd2;
    localparam logic [2:0] RS_RESOLVED = 3'd3;
    localparam logic [2:0] RS_NO_ENTRY = 3'd4;
    localparam logic [2:0] RS_TICK     = 3'd5;

    localparam logic [0:0] CFG_LIFETIME = 1'b0;
    localparam logic [0:0] CFG_MAX_ATT  = 1'b1;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] ip_addr;
        logic [47:0] mac_addr;
        logic [15:0] elapsed;
    } t_item;

    typedef struct packed {
        logic  valid;
        logic  ready;
    } t_qctl;
endpackage
`default_nettype wire

@@ hdl/act_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// act_front: command intake
// Takes an item on start and pushes it into a short queue for the back end.
// ----------------------------------------------------------------------------
module act_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire act_pkg::t_item i_item,
    input  wire logic          i_pop,
    output act_pkg::t_qctl     o_ctl,
    output act_pkg::t_item     o_item
);
    import act_pkg::*;

    t_item             r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QPTR_W:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_q[r_wp] <= i_item;
                r_wp      <= r_wp + 1'b1;
            end
            if (i_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + {{QPTR_W{1'b0}}, i_push} - {{QPTR_W{1'b0}}, i_pop};
        end
    end

    assign o_ctl.valid = (r_cnt != '0);
    assign o_ctl.ready = (r_cnt != (QPTR_W+1)'(QDEPTH));
    assign o_item      = r_q[r_rp];
endmodule
`default_nettype wire

@@ hdl/act_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// act_back: table and executor
// Holds the entries, matches addresses in parallel and applies each item.
// ----------------------------------------------------------------------------
module act_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire act_pkg::t_qctl i_ctl,
    input  wire act_pkg::t_item i_item,
    output logic                o_pop,
    input  wire logic           i_cfg_we,
    input  wire logic [0:0]     i_cfg_idx,
    input  wire logic [31:0]    i_cfg_data,
    output logic                o_strobe,
    output logic [4:0]          o_slot,
    output logic [2:0]          o_status,
    output logic [1:0]          o_entry_state
);
    import act_pkg::*;

    logic [31:0] r_ip  [ENTRIES];
    logic [47:0] r_mac [ENTRIES];
    logic [1:0]  r_st  [ENTRIES];
    logic [3:0]  r_tr  [ENTRIES];
    logic [15:0] r_rem [ENTRIES];
    logic [15:0] r_life;
    logic [3:0]  r_maxa;

    logic [ENTRIES-1:0] hit, fre, giveup;
    logic               any_hit, any_free, any_give;
    logic [IDX_W-1:0]   hit_k, free_k, give_k;

    always_comb begin
        any_hit = 1'b0; any_free = 1'b0; any_give = 1'b0;
        hit_k = '0; free_k = '0; give_k = '0;
        for (int k = 0; k < ENTRIES; k++) begin
            hit[k]    = (r_st[k] != ST_FREE) && (r_ip[k] == i_item.ip_addr);
            fre[k]    = (r_st[k] == ST_FREE);
            giveup[k] = (r_st[k] == ST_PENDING) && (r_tr[k] >= r_maxa);
        end
        for (int k = ENTRIES-1; k >= 0; k--) begin
            if (hit[k])    begin any_hit  = 1'b1; hit_k  = IDX_W'(k); end
            if (fre[k])    begin any_free = 1'b1; free_k = IDX_W'(k); end
            if (giveup[k]) begin any_give = 1'b1; give_k = IDX_W'(k); end
        end
    end

    assign o_pop = i_ctl.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ENTRIES; k++) begin
                r_ip[k] <= '0; r_mac[k] <= '0; r_st[k] <= ST_FREE;
                r_tr[k] <= '0; r_rem[k] <= '0;
            end
            r_life   <= 16'd300;
            r_maxa   <= 4'd5;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= i_ctl.valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LIFETIME: r_life <= i_cfg_data[15:0];
                    CFG_MAX_ATT:  r_maxa <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (i_ctl.valid) begin
                o_slot <= '0; o_status <= RS_NO_ENTRY; o_entry_state <= ST_FREE;
                case (i_item.mode)
                    MODE_REQ: begin
                        if (any_hit) begin
                            o_slot <= 5'(hit_k) + 5'd1;
                            o_status <= RS_PRESENT;
                            o_entry_state <= r_st[hit_k];
                        end else if (!any_free) begin
                            o_status <= RS_FULL;
                        end else begin
                            r_ip[free_k] <= i_item.ip_addr;
                            r_mac[free_k] <= '0;
                            r_st[free_k] <= ST_PENDING;
                            r_tr[free_k] <= 4'd1;
                            r_rem[free_k] <= '0;
                            o_slot <= 5'(free_k) + 5'd1;
                            o_status <= RS_NEW;
                            o_entry_state <= ST_PENDING;
                        end
                    end
                    MODE_REPLY: begin
                        if (any_hit) begin
                            r_mac[hit_k] <= i_item.mac_addr;
                            r_st[hit_k] <= ST_RESOLVED;
                            r_rem[hit_k] <= r_life;
                            o_slot <= 5'(hit_k) + 5'd1;
                            o_status <= RS_RESOLVED;
                            o_entry_state <= ST_RESOLVED;
                        end
                    end
                    MODE_TICK: begin
                        // entries past the first give-up are untouched
                        for (int k = 0; k < ENTRIES; k++) begin
                            if (!any_give || IDX_W'(k) < give_k) begin
                                if (r_st[k] == ST_RESOLVED) begin
                                    if (r_rem[k] > i_item.elapsed)
                                        r_rem[k] <= r_rem[k] - i_item.elapsed;
                                    else begin
                                        r_ip[k] <= '0; r_mac[k] <= '0;
                                        r_st[k] <= ST_FREE; r_tr[k] <= '0;
                                        r_rem[k] <= '0;
                                    end
                                end else if (r_st[k] == ST_PENDING && r_tr[k] != 4'hF)
                                    r_tr[k] <= r_tr[k] + 1'b1;
                            end
                        end
                        if (any_give) begin
                            r_ip[give_k] <= '0; r_mac[give_k] <= '0;
                            r_st[give_k] <= ST_FREE; r_tr[give_k] <= '0;
                            r_rem[give_k] <= '0;
                            o_slot <= 5'(give_k) + 5'd1;
                        end
                        o_status <= RS_TICK;
                    end
                    default: ;
                endcase
            end
        end
    end
endmodule
`default_nettype wire

@@ hdl/arp_cache_table_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// arp_cache_table_unit: address-resolution cache
// Sixteen-entry IP to MAC cache with request, reply and aging tick commands.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive i_mode/i_ip_addr/i_mac_addr/i_elapsed with
//   i_start; the item is taken on a cycle where o_busy is low.
//   Every item gives one result on o_slot/o_status/o_entry_state, marked by
//   o_done for one cycle; the item is first registered in the act_front
//   queue, and act_back then registers the result.
//   A two-item queue sits between intake and the table; the table retires
//   one item per cycle, so the queue never fills and o_busy stays low: a new
//   item can be taken every cycle.
//   Lookups compare all entries in parallel; a tick ages, in the same cycle,
//   every entry below the first one to give up (all if none does) and frees that one.
//   Config: i_cfg_valid/i_cfg_addr/i_cfg_data, always ready; write only
//   while idle. Reset frees all entries, lifetime 300, max attempts 5.
//   The receiver cannot stall: a result is shown exactly once.
// ----------------------------------------------------------------------------
module arp_cache_table_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [1:0]  i_mode,
    input  wire logic [31:0] i_ip_addr,
    input  wire logic [47:0] i_mac_addr,
    input  wire logic [15:0] i_elapsed,
    output logic             o_done,
    output logic [4:0]       o_slot,
    output logic [2:0]       o_status,
    output logic [1:0]       o_entry_state,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [0:0]  i_cfg_addr,
    input  wire logic [31:0] i_cfg_data
);
    import act_pkg::*;

    t_item item, q_item;
    t_qctl q_ctl;
    logic  pop;

    assign item = '{mode: i_mode, ip_addr: i_ip_addr, mac_addr: i_mac_addr,
                    elapsed: i_elapsed};
    assign o_busy      = !q_ctl.ready;
    assign o_cfg_ready = 1'b1;

    act_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_start && q_ctl.ready),
        .i_item(item), .i_pop(pop), .o_ctl(q_ctl), .o_item(q_item)
    );

    act_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(q_ctl), .i_item(q_item),
        .o_pop(pop), .i_cfg_we(i_cfg_valid), .i_cfg_idx(i_cfg_addr),
        .i_cfg_data(i_cfg_data), .o_strobe(o_done), .o_slot(o_slot),
        .o_status(o_status), .o_entry_state(o_entry_state)
    );
endmodule
`default_nettype wire

@@ hdl/act_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// act_checker: port-level checks
// Watches result codes and slot ranges on the top-level ports.
// ----------------------------------------------------------------------------
module act_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_done,
    input wire logic [4:0] o_slot,
    input wire logic [2:0] o_status,
    input wire logic [1:0] o_entry_state
);
    import act_pkg::*;

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_status <= RS_TICK) else $error("bad status");
    a_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_slot <= 5'(ENTRIES)) else $error("bad slot");
    a_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_status == RS_FULL || o_status == RS_NO_ENTRY) |-> o_slot == 5'd0
        && o_entry_state == ST_FREE) else $error("miss with slot");
    a_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_status == RS_NEW || o_status == RS_RESOLVED) |-> o_slot != 5'd0)
        else $error("hit without slot");
endmodule

bind arp_cache_table_unit act_checker u_act_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_done(o_done), .o_slot(o_slot),
    .o_status(o_status), .o_entry_state(o_entry_state)
);
`default_nettype wire

@@ verif/arp_cache_table_unit_test.sv @@
// ----------------------------------------------------------------------------
// arp_cache_table_unit_test: self-checking bench for the ARP cache
// Drives request, reply, tick and unused-mode items with random gaps (none in the
// quiet phase), predicts every result from a local copy of the table, and checks each strobed result.
// ----------------------------------------------------------------------------
module arp_cache_table_unit_test;
    import act_pkg::*;

    typedef struct packed {
        logic [4:0] slot;
        logic [2:0] status;
        logic [1:0] st;
    } t_res;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] ip;
        logic [47:0] mac;
        logic [15:0] elapsed;
        logic        has_exp;
        t_res        exp_res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic [1:0]  i_mode = '0;
    logic [31:0] i_ip_addr = '0;
    logic [47:0] i_mac_addr = '0;
    logic [15:0] i_elapsed = '0;
    logic        i_cfg_valid = 1'b0;
    logic [0:0]  i_cfg_addr = '0;
    logic [31:0] i_cfg_data = '0;
    logic        o_busy, o_done, o_cfg_ready;
    logic [4:0]  o_slot;
    logic [2:0]  o_status;
    logic [1:0]  o_entry_state;

    arp_cache_table_unit dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state
    logic [31:0] tbl_ip [ENTRIES];
    logic [47:0] tbl_mac [ENTRIES];
    logic [1:0]  tbl_st [ENTRIES];
    logic [3:0]  tbl_tries [ENTRIES];
    logic [15:0] tbl_life [ENTRIES];
    logic [15:0] cfg_lifetime;
    logic [3:0]  cfg_max_att;

    t_res pending_res [$];
    int   fails = 0;
    bit   quiet = 0;
    logic [31:0] ip_pool [8];

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        fails++;
    endtask

    function automatic void table_clear(int k);
        tbl_ip[k] = '0; tbl_mac[k] = '0; tbl_st[k] = ST_FREE;
        tbl_tries[k] = '0; tbl_life[k] = '0;
    endfunction

    function automatic t_res cache_predict(logic [1:0] mode, logic [31:0] ip,
                                           logic [47:0] mac, logic [15:0] el);
        int hit, fr;
        t_res r;
        hit = -1; fr = -1;
        r = '{slot: 5'd0, status: RS_NO_ENTRY, st: ST_FREE};
        for (int k = ENTRIES - 1; k >= 0; k--) begin
            if (tbl_st[k] != ST_FREE && tbl_ip[k] == ip) hit = k;
            if (tbl_st[k] == ST_FREE) fr = k;
        end
        case (mode)
            MODE_REQ: begin
                if (hit >= 0) r = '{5'(hit + 1), RS_PRESENT, tbl_st[hit]};
                else if (fr < 0) r = '{5'd0, RS_FULL, ST_FREE};
                else begin
                    tbl_ip[fr] = ip; tbl_mac[fr] = '0; tbl_st[fr] = ST_PENDING;
                    tbl_tries[fr] = 4'd1; tbl_life[fr] = '0;
                    r = '{5'(fr + 1), RS_NEW, ST_PENDING};
                end
            end
            MODE_REPLY: begin
                if (hit >= 0) begin
                    tbl_mac[hit] = mac; tbl_st[hit] = ST_RESOLVED;
                    tbl_life[hit] = cfg_lifetime;
                    r = '{5'(hit + 1), RS_RESOLVED, ST_RESOLVED};
                end
            end
            MODE_TICK: begin
                r = '{5'd0, RS_TICK, ST_FREE};
                for (int k = 0; k < ENTRIES; k++) begin
                    if (tbl_st[k] == ST_RESOLVED) begin
                        tbl_life[k] = (tbl_life[k] > el) ? tbl_life[k] - el : 16'd0;
                        if (tbl_life[k] == 0) table_clear(k);
                    end else if (tbl_st[k] == ST_PENDING) begin
                        if (tbl_tries[k] >= cfg_max_att) begin
                            table_clear(k);
                            r.slot = 5'(k + 1);
                            break;
                        end
                        if (tbl_tries[k] != 4'd15) tbl_tries[k]++;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_res.size() == 0) begin
                report_mismatch("unexpected result", o_status, -1);
            end else begin
                t_res e;
                e = pending_res.pop_front();
                if (o_slot !== e.slot) report_mismatch("slot", o_slot, e.slot);
                if (o_status !== e.status) report_mismatch("status", o_status, e.status);
                if (o_entry_state !== e.st) report_mismatch("entry_state", o_entry_state, e.st);
            end
        end
    end

    task automatic send_item(input logic [1:0] mode, input logic [31:0] ip,
                             input logic [47:0] mac, input logic [15:0] el,
                             input bit has_exp, input t_res exp_res);
        t_res p;
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            i_start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_start <= 1'b1;
        i_mode <= mode; i_ip_addr <= ip; i_mac_addr <= mac; i_elapsed <= el;
        do @(posedge i_clk); while (o_busy);
        p = cache_predict(mode, ip, mac, el);
        if (has_exp && p !== exp_res)
            report_mismatch("typed expectation", p, exp_res);
        pending_res.push_back(p);
        @(negedge i_clk);
    endtask

    task automatic drain_idle();
        i_start <= 1'b0;
        while (pending_res.size() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [0:0] idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1; i_cfg_addr <= idx; i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_LIFETIME) cfg_lifetime = val[15:0];
        else cfg_max_att = val[3:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // random item: mostly addresses from a small pool so hits happen
    task automatic random_item();
        logic [1:0] m;
        logic [31:0] ip;
        int r;
        r = $urandom_range(0, 99);
        m = (r < 45) ? MODE_REQ : (r < 80) ? MODE_REPLY : (r < 98) ? MODE_TICK : 2'd3;
        ip = ($urandom_range(0, 9) == 0) ? $urandom() : ip_pool[$urandom_range(0, 7)];
        send_item(m, ip, {$urandom(), $urandom()}, 16'($urandom_range(0, 3) == 0 ?
                  $urandom() : $urandom_range(0, 120)), 1'b0, '0);
    endtask

    t_row rows [$];

    initial begin
        for (int k = 0; k < ENTRIES; k++) table_clear(k);
        cfg_lifetime = 16'd300;
        cfg_max_att = 4'd5;
        for (int k = 0; k < 8; k++) ip_pool[k] = $urandom();
        ip_pool[0] = 32'h0; ip_pool[1] = 32'hFFFF_FFFF;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table
        rows.push_back('{MODE_REPLY, 32'h0, 48'h0, 16'h0, 1'b1, '{5'd0, RS_NO_ENTRY, ST_FREE}});
        rows.push_back('{MODE_TICK, 32'h0, 48'h0, 16'h0, 1'b1, '{5'd0, RS_TICK, ST_FREE}});
        rows.push_back('{MODE_REQ, 32'h0, 48'h0, 16'h0, 1'b1, '{5'd1, RS_NEW, ST_PENDING}});
        rows.push_back('{MODE_REQ, 32'h0, 48'h0, 16'h0, 1'b1, '{5'd1, RS_PRESENT, ST_PENDING}});
        rows.push_back('{MODE_REQ, 32'hFFFF_FFFF, 48'h0, 16'h0, 1'b1,
                         '{5'd2, RS_NEW, ST_PENDING}});
        rows.push_back('{MODE_REPLY, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'h0, 1'b1,
                         '{5'd2, RS_RESOLVED, ST_RESOLVED}});
        rows.push_back('{MODE_REQ, 32'hFFFF_FFFF, 48'h0, 16'h0, 1'b1,
                         '{5'd2, RS_PRESENT, ST_RESOLVED}});
        rows.push_back('{2'd3, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 1'b1,
                         '{5'd0, RS_NO_ENTRY, ST_FREE}});
        for (int k = 0; k < 4; k++)
            rows.push_back('{MODE_TICK, 32'h0, 48'h0, 16'd1, 1'b0, '0});
        rows.push_back('{MODE_TICK, 32'h0, 48'h0, 16'hFFFF, 1'b0, '0});
        foreach (rows[i])
            send_item(rows[i].mode, rows[i].ip, rows[i].mac, rows[i].elapsed,
                      rows[i].has_exp, rows[i].exp_res);
        // fill the table, then overflow
        for (int k = 0; k < ENTRIES + 1; k++)
            send_item(MODE_REQ, 32'h0A00_0000 + k, '0, '0, 1'b0, '0);
        drain_idle();

        // random phases across register settings, extremes included
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin write_cfg(CFG_LIFETIME, 32'd1); write_cfg(CFG_MAX_ATT, 32'd1); end
                1: begin write_cfg(CFG_LIFETIME, 32'hFFFF); write_cfg(CFG_MAX_ATT, 32'd15); end
                2: begin write_cfg(CFG_LIFETIME, 32'd300); write_cfg(CFG_MAX_ATT, 32'd5); end
                default: begin
                    write_cfg(CFG_LIFETIME, 32'($urandom_range(1, 65535)));
                    write_cfg(CFG_MAX_ATT, 32'($urandom_range(1, 15)));
                end
            endcase
            quiet = (ph == 4);
            for (int n = 0; n < 205; n++) random_item();
            drain_idle();
        end

        if (fails == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

    initial begin
        #400000;
        $display("status: fail");
        $finish;
    end
endmodule
